@@ src/json_string_unescape_decoder_unit_macros.svh @@
// Assertion macros for the JSON string decoder.
// Included by the module that carries concurrent checks; no dependencies.
`ifndef JSON_STRING_UNESCAPE_DECODER_UNIT_MACROS_SVH
`define JSON_STRING_UNESCAPE_DECODER_UNIT_MACROS_SVH

// same-cycle implication, disabled in reset
`define JSUD_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled in reset
`define JSUD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/jsud_pkg.sv @@
// Package for the JSON string decoder: result word type, kind and error codes,
// character constants and small decode helpers. No dependencies.
`timescale 1ns / 1ps

package jsud_pkg;

    localparam int RES_DEPTH = 4;
    localparam int RES_PTR_W = $clog2(RES_DEPTH);
    localparam int RES_CNT_W = $clog2(RES_DEPTH + 1);

    localparam logic [1:0] KIND_CP  = 2'd0;
    localparam logic [1:0] KIND_END = 2'd1;
    localparam logic [1:0] KIND_ERR = 2'd2;

    localparam logic [2:0] ERR_NUL_PLAIN = 3'd0;
    localparam logic [2:0] ERR_BAD_LEAD  = 3'd1;
    localparam logic [2:0] ERR_BAD_CONT  = 3'd2;
    localparam logic [2:0] ERR_OVERLONG  = 3'd3;
    localparam logic [2:0] ERR_NUL_ESC   = 3'd4;
    localparam logic [2:0] ERR_BAD_ESC   = 3'd5;
    localparam logic [2:0] ERR_NUL_HEX   = 3'd6;
    localparam logic [2:0] ERR_BAD_HEX   = 3'd7;

    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_B      = 8'h62;
    localparam logic [7:0] CH_F      = 8'h66;
    localparam logic [7:0] CH_N      = 8'h6E;
    localparam logic [7:0] CH_R      = 8'h72;
    localparam logic [7:0] CH_T      = 8'h74;
    localparam logic [7:0] CH_U      = 8'h75;

    typedef struct packed {
        logic [20:0] code_point;
        logic [1:0]  kind;
        logic [2:0]  error_code;
        logic        last;
    } t_result;

    // {valid, value} of one ASCII hex digit
    function automatic logic [4:0] hex_digit(input logic [7:0] b);
        logic [4:0] r;
        r = 5'd0;
        if (b >= 8'h30 && b <= 8'h39) begin
            r = {1'b1, b[3:0]};
        end else if ((b >= 8'h61 && b <= 8'h66) || (b >= 8'h41 && b <= 8'h46)) begin
            r = {1'b1, b[3:0] + 4'd9};
        end
        return r;
    endfunction

    // smallest legal value for a sequence of (len + 1) bytes
    function automatic logic [20:0] overlong_floor(input logic [1:0] len);
        logic [20:0] r;
        unique case (len)
            2'd1:    r = 21'h00080;
            2'd2:    r = 21'h00800;
            2'd3:    r = 21'h10000;
            default: r = 21'h00000;
        endcase
        return r;
    endfunction

endpackage

@@ src/json_string_unescape_decoder_unit.sv @@
// JSON string body decoder: escapes, \uXXXX with surrogate merge, UTF-8.
// Single module; uses jsud_pkg and json_string_unescape_decoder_unit_macros.svh.
//
// channel  dir  valid    stall    payload
// input    in   i_valid  o_stall  i_in_byte
// result   out  o_valid  i_stall  o_code_point, o_kind, o_error_code, o_last
//
// One byte per cycle while o_stall is low; a byte that flushes a held surrogate
// can make two words, and the single result port sends one word per cycle
// while i_stall is low. Path: byte register, decode, result queue, whose head
// drives the outputs; o_stall holds the byte register while decode cannot fire.
// Decode fires only with at least two free slots in the four-word result queue.
// Synchronous active-low reset clears the scan state and the queue.
`timescale 1ns / 1ps

`include "json_string_unescape_decoder_unit_macros.svh"

module json_string_unescape_decoder_unit
    import jsud_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_in_byte,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [20:0] o_code_point,
    output logic [1:0]  o_kind,
    output logic [2:0]  o_error_code,
    output logic        o_last
);

    typedef enum logic [1:0] {M_PLAIN, M_ESC, M_HEX, M_UTF} t_mode;

    // input register
    logic       r_in_valid;
    logic [7:0] r_in_byte;

    // scan state
    t_mode       r_mode, n_mode;
    logic [1:0]  r_hex_seen, n_hex_seen;
    logic [15:0] r_hex_acc, n_hex_acc;
    logic [20:0] r_utf_acc, n_utf_acc;
    logic [1:0]  r_utf_left, n_utf_left;
    logic [1:0]  r_utf_len, n_utf_len;
    logic        r_high_pending, n_high_pending;
    logic [15:0] r_high_value, n_high_value;

    // result queue
    t_result              r_fifo [RES_DEPTH];
    logic [RES_PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [RES_CNT_W-1:0] r_count;

    logic        fire, pop;
    logic        main_v, flush, clear_all, flush_emit;
    logic [20:0] main_cp;
    logic [1:0]  main_kind;
    logic [2:0]  main_err;
    logic [4:0]  hex_d;
    logic [15:0] hex_acc_new;
    logic [20:0] utf_acc_new;
    logic [1:0]  utf_left_new;
    logic [7:0]  b;
    t_result     res0, res1;
    logic [1:0]  res_cnt;

    assign b = r_in_byte;
    assign fire = r_in_valid && (r_count <= RES_CNT_W'(RES_DEPTH - 2));
    assign o_stall = r_in_valid && !fire;
    assign o_valid = (r_count != '0);
    assign pop = o_valid && !i_stall;

    assign o_code_point = r_fifo[r_rd_ptr].code_point;
    assign o_kind       = r_fifo[r_rd_ptr].kind;
    assign o_error_code = r_fifo[r_rd_ptr].error_code;
    assign o_last       = r_fifo[r_rd_ptr].last;

    assign hex_d        = hex_digit(b);
    assign hex_acc_new  = {r_hex_acc[11:0], hex_d[3:0]};
    assign utf_acc_new  = {r_utf_acc[14:0], b[5:0]};
    assign utf_left_new = r_utf_left - 2'd1;

    always_comb begin
        n_mode         = r_mode;
        n_hex_seen     = r_hex_seen;
        n_hex_acc      = r_hex_acc;
        n_utf_acc      = r_utf_acc;
        n_utf_left     = r_utf_left;
        n_utf_len      = r_utf_len;
        n_high_pending = r_high_pending;
        n_high_value   = r_high_value;
        main_v    = 1'b0;
        main_cp   = '0;
        main_kind = KIND_CP;
        main_err  = '0;
        flush     = 1'b0;
        clear_all = 1'b0;

        unique case (r_mode)
            M_PLAIN: begin
                priority if (b == CH_BSLASH) begin
                    n_mode = M_ESC;
                end else if (b == CH_NUL) begin
                    main_v = 1'b1; main_kind = KIND_ERR; main_err = ERR_NUL_PLAIN;
                    flush = 1'b1; clear_all = 1'b1;
                end else if (b == CH_QUOTE) begin
                    main_v = 1'b1; main_kind = KIND_END;
                    flush = 1'b1; clear_all = 1'b1;
                end else if (b >= 8'hF8) begin
                    main_v = 1'b1; main_kind = KIND_ERR; main_err = ERR_BAD_LEAD;
                    flush = 1'b1; clear_all = 1'b1;
                end else if (b >= 8'hC0) begin
                    flush = 1'b1;
                    priority if (b >= 8'hF0) begin
                        n_utf_acc = {18'd0, b[2:0]};
                        n_utf_len = 2'd3;
                    end else if (b >= 8'hE0) begin
                        n_utf_acc = {17'd0, b[3:0]};
                        n_utf_len = 2'd2;
                    end else begin
                        n_utf_acc = {16'd0, b[4:0]};
                        n_utf_len = 2'd1;
                    end
                    n_utf_left = n_utf_len;
                    n_mode = M_UTF;
                end else begin
                    flush = 1'b1;
                    main_v = 1'b1; main_cp = {13'd0, b};
                end
            end
            M_ESC: begin
                priority if (b == CH_BSLASH || b == CH_QUOTE || b == CH_SLASH) begin
                    flush = 1'b1; main_v = 1'b1; main_cp = {13'd0, b};
                    n_mode = M_PLAIN;
                end else if (b == CH_B) begin
                    flush = 1'b1; main_v = 1'b1; main_cp = 21'h08; n_mode = M_PLAIN;
                end else if (b == CH_F) begin
                    flush = 1'b1; main_v = 1'b1; main_cp = 21'h0C; n_mode = M_PLAIN;
                end else if (b == CH_N) begin
                    flush = 1'b1; main_v = 1'b1; main_cp = 21'h0A; n_mode = M_PLAIN;
                end else if (b == CH_R) begin
                    flush = 1'b1; main_v = 1'b1; main_cp = 21'h0D; n_mode = M_PLAIN;
                end else if (b == CH_T) begin
                    flush = 1'b1; main_v = 1'b1; main_cp = 21'h09; n_mode = M_PLAIN;
                end else if (b == CH_U) begin
                    n_mode = M_HEX; n_hex_seen = 2'd0; n_hex_acc = '0;
                end else if (b == CH_NUL) begin
                    main_v = 1'b1; main_kind = KIND_ERR; main_err = ERR_NUL_ESC;
                    flush = 1'b1; clear_all = 1'b1;
                end else begin
                    main_v = 1'b1; main_kind = KIND_ERR; main_err = ERR_BAD_ESC;
                    flush = 1'b1; clear_all = 1'b1;
                end
            end
            M_HEX: begin
                priority if (b == CH_NUL) begin
                    main_v = 1'b1; main_kind = KIND_ERR; main_err = ERR_NUL_HEX;
                    flush = 1'b1; clear_all = 1'b1;
                end else if (!hex_d[4]) begin
                    main_v = 1'b1; main_kind = KIND_ERR; main_err = ERR_BAD_HEX;
                    flush = 1'b1; clear_all = 1'b1;
                end else begin
                    n_hex_acc = hex_acc_new;
                    if (r_hex_seen == 2'd3) begin
                        n_hex_seen = 2'd0;
                        n_mode = M_PLAIN;
                        if (r_high_pending && hex_acc_new[15:10] == 6'b110111) begin
                            // low surrogate joins the held high one
                            main_v = 1'b1;
                            main_cp = {1'b0, r_high_value[9:0], hex_acc_new[9:0]}
                                      + 21'h10000;
                            n_high_pending = 1'b0;
                            n_high_value = '0;
                        end else begin
                            flush = 1'b1;
                            if (hex_acc_new[15:10] == 6'b110110) begin
                                n_high_pending = 1'b1;
                                n_high_value = hex_acc_new;
                            end else begin
                                main_v = 1'b1;
                                main_cp = {5'd0, hex_acc_new};
                            end
                        end
                    end else begin
                        n_hex_seen = r_hex_seen + 2'd1;
                    end
                end
            end
            M_UTF: begin
                if (!b[7]) begin
                    main_v = 1'b1; main_kind = KIND_ERR; main_err = ERR_BAD_CONT;
                    flush = 1'b1; clear_all = 1'b1;
                end else begin
                    n_utf_acc = utf_acc_new;
                    n_utf_left = utf_left_new;
                    if (utf_left_new == 2'd0) begin
                        if (utf_acc_new < overlong_floor(r_utf_len)) begin
                            main_v = 1'b1; main_kind = KIND_ERR; main_err = ERR_OVERLONG;
                            flush = 1'b1; clear_all = 1'b1;
                        end else begin
                            main_v = 1'b1; main_cp = utf_acc_new;
                            n_utf_acc = '0;
                            n_utf_len = 2'd0;
                            n_mode = M_PLAIN;
                        end
                    end
                end
            end
            default: begin
                n_mode = M_PLAIN;
            end
        endcase

        // a new high surrogate replaces the flushed one
        flush_emit = flush && r_high_pending;
        if (flush_emit && !(r_mode == M_HEX && hex_acc_new[15:10] == 6'b110110)) begin
            n_high_pending = 1'b0;
            n_high_value = '0;
        end
        if (clear_all) begin
            n_mode         = M_PLAIN;
            n_hex_seen     = '0;
            n_hex_acc      = '0;
            n_utf_acc      = '0;
            n_utf_left     = '0;
            n_utf_len      = '0;
            n_high_pending = 1'b0;
            n_high_value   = '0;
        end

        res0 = '{code_point: {5'd0, r_high_value}, kind: KIND_CP, error_code: '0, last: 1'b0};
        res1 = '{code_point: main_cp, kind: main_kind, error_code: main_err, last: 1'b1};
        res_cnt = 2'd0;
        if (flush_emit) begin
            if (main_v) begin
                res_cnt = 2'd2;
            end else begin
                res0.last = 1'b1;
                res_cnt = 2'd1;
            end
        end else if (main_v) begin
            res0 = res1;
            res_cnt = 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid     <= 1'b0;
            r_mode         <= M_PLAIN;
            r_hex_seen     <= '0;
            r_hex_acc      <= '0;
            r_utf_acc      <= '0;
            r_utf_left     <= '0;
            r_utf_len      <= '0;
            r_high_pending <= 1'b0;
            r_high_value   <= '0;
            r_wr_ptr       <= '0;
            r_rd_ptr       <= '0;
            r_count        <= '0;
        end else begin
            if (!o_stall) begin
                r_in_valid <= i_valid;
            end
            if (fire) begin
                r_mode         <= n_mode;
                r_hex_seen     <= n_hex_seen;
                r_hex_acc      <= n_hex_acc;
                r_utf_acc      <= n_utf_acc;
                r_utf_left     <= n_utf_left;
                r_utf_len      <= n_utf_len;
                r_high_pending <= n_high_pending;
                r_high_value   <= n_high_value;
                r_wr_ptr       <= r_wr_ptr + RES_PTR_W'(res_cnt);
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + RES_PTR_W'(1);
            end
            r_count <= r_count + (fire ? RES_CNT_W'(res_cnt) : '0)
                       - (pop ? RES_CNT_W'(1) : '0);
        end
    end

    // payload storage, no reset
    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_in_byte <= i_in_byte;
        end
        if (fire && res_cnt != 2'd0) begin
            r_fifo[r_wr_ptr] <= res0;
        end
        if (fire && res_cnt == 2'd2) begin
            r_fifo[r_wr_ptr + RES_PTR_W'(1)] <= res1;
        end
    end

    `JSUD_ASSERT_NOW(a_queue_bound, i_clk, i_rst_n, 1'b1,
        r_count <= RES_CNT_W'(RES_DEPTH), "result queue overflow")
    `JSUD_ASSERT_NEXT(a_done_resets, i_clk, i_rst_n, fire && main_v && main_kind != KIND_CP,
        r_mode == M_PLAIN && !r_high_pending, "state not cleared after end or error")
    `JSUD_ASSERT_NOW(a_no_hold_in_utf, i_clk, i_rst_n, r_high_pending,
        r_mode != M_UTF, "surrogate held inside a UTF-8 sequence")
    `JSUD_ASSERT_NOW(a_cp_zero, i_clk, i_rst_n, o_valid && o_kind != KIND_CP,
        o_code_point == 21'd0, "nonzero code point on end or error word")
    `JSUD_ASSERT_NOW(a_err_zero, i_clk, i_rst_n, o_valid && o_kind != KIND_ERR,
        o_error_code == 3'd0, "error code set on non-error word")

endmodule
